[rtl/fcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_pkg
// Types and command codes for the flash command sequencer.
// ----------------------------------------------------------------------------
package fcs_pkg;

  // Per-chip sequencer mode
  typedef enum logic [1:0] {
    MODE_READY   = 2'd0,
    MODE_COMMAND = 2'd1,
    MODE_PROGRAM = 2'd2,
    MODE_ERASE   = 2'd3
  } mode_t;

  // Action handed to the flash array
  typedef enum logic [1:0] {
    ACT_NONE         = 2'd0,
    ACT_PROGRAM      = 2'd1,
    ACT_CHIP_ERASE   = 2'd2,
    ACT_SECTOR_ERASE = 2'd3
  } action_t;

  // Command cycles decode only the low address bits
  localparam int CMD_ADDR_BITS = 15;

  localparam logic [CMD_ADDR_BITS-1:0] UNLOCK_ADDR_1 = 15'h5555;
  localparam logic [CMD_ADDR_BITS-1:0] UNLOCK_ADDR_2 = 15'h2AAA;

  localparam logic [7:0] UNLOCK_DATA_1   = 8'hAA;
  localparam logic [7:0] UNLOCK_DATA_2   = 8'h55;
  localparam logic [7:0] CMD_PROGRAM     = 8'hA0;
  localparam logic [7:0] CMD_ERASE_SETUP = 8'h80;
  localparam logic [7:0] CMD_ID_ENTRY    = 8'h90;
  localparam logic [7:0] CMD_ID_EXIT     = 8'hF0;
  localparam logic [7:0] CMD_CHIP_ERASE  = 8'h10;
  localparam logic [7:0] CMD_SECTOR_ERASE = 8'h30;

  // Sequence steps
  localparam logic [1:0] STEP_0 = 2'd0;
  localparam logic [1:0] STEP_1 = 2'd1;
  localparam logic [1:0] STEP_2 = 2'd2;

endpackage

[rtl/flash_command_sequencer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_command_sequencer_unit
// JEDEC style command decoder for two byte-wide flash chips. Every write word
// yields one action word for the flash array.
// ----------------------------------------------------------------------------
// The result is registered: it is valid in the cycle after the input is accepted.
// Throughput: one word per cycle; the per-chip state lookup and update is the
// only path. A result held by m_tready low stalls the input; a new word enters
// in the same cycle its predecessor is taken.
// Reset (rst, synchronous): both chips ready, step 0, ID mode off; output empty.
module flash_command_sequencer_unit #(
  parameter int ADDRESS_BITS = 19,
  parameter int SECTOR_BITS  = 12,
  localparam int IN_W  = ((ADDRESS_BITS + 8 + 7) / 8) * 8,
  localparam int OUT_W = ((ADDRESS_BITS + 9 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // flash_address, write_data
  input  logic             s_tuser,   // chip_select
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // target_address, program_data, id_mode
  output fcs_pkg::action_t m_tuser    // action
);
  import fcs_pkg::*;

  localparam logic [ADDRESS_BITS-1:0] SECTOR_MASK = {ADDRESS_BITS{1'b1}} << SECTOR_BITS;

  mode_t       chip_mode [2];
  logic [1:0]  sequence_step [2];
  logic        software_id_flag [2];

  action_t                 out_action;
  logic [ADDRESS_BITS-1:0] out_target;
  logic [7:0]              out_data;
  logic                    out_id;

  logic                     accept;
  logic                     sel;
  logic [ADDRESS_BITS-1:0]  addr;
  logic [7:0]               din;
  logic [CMD_ADDR_BITS-1:0] cmd;
  mode_t                    mode_cur, mode_next;
  logic [1:0]               seq_next;
  logic                     id_next;
  action_t                  act_next;
  logic [ADDRESS_BITS-1:0]  target_next;
  logic [7:0]               data_next;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign sel      = s_tuser;
  assign addr     = s_tdata[ADDRESS_BITS-1:0];
  assign din      = s_tdata[ADDRESS_BITS +: 8];
  assign cmd      = addr[CMD_ADDR_BITS-1:0];
  assign mode_cur = chip_mode[sel];

  always_comb begin
    mode_next   = mode_cur;
    seq_next    = sequence_step[sel];
    id_next     = software_id_flag[sel];
    act_next    = ACT_NONE;
    target_next = '0;
    data_next   = '0;
    unique case (mode_cur)
      MODE_READY: begin
        if (cmd == UNLOCK_ADDR_1 && din == UNLOCK_DATA_1) begin
          mode_next = MODE_COMMAND;
          seq_next  = STEP_0;
        end else if (din == CMD_ID_EXIT) begin
          id_next = 1'b0;
        end
      end
      MODE_COMMAND: begin
        if (sequence_step[sel] == STEP_0) begin
          if (cmd == UNLOCK_ADDR_2 && din == UNLOCK_DATA_2) seq_next = STEP_1;
          else mode_next = MODE_READY;
        end else if (sequence_step[sel] == STEP_1 && cmd == UNLOCK_ADDR_1) begin
          seq_next  = STEP_0;
          mode_next = MODE_READY;
          if (din == CMD_PROGRAM) mode_next = MODE_PROGRAM;
          else if (din == CMD_ERASE_SETUP) mode_next = MODE_ERASE;
          else if (din == CMD_ID_ENTRY) id_next = 1'b1;
          else if (din == CMD_ID_EXIT) id_next = 1'b0;
        end else begin
          mode_next = MODE_READY;
        end
      end
      MODE_PROGRAM: begin
        act_next    = ACT_PROGRAM;
        target_next = addr;
        data_next   = din;
        mode_next   = MODE_READY;
      end
      MODE_ERASE: begin
        // erase tail: second unlock pair, then 10 at 5555 or 30 anywhere
        mode_next = MODE_READY;
        if (sequence_step[sel] == STEP_0) begin
          if (cmd == UNLOCK_ADDR_1 && din == UNLOCK_DATA_1) begin
            seq_next  = STEP_1;
            mode_next = MODE_ERASE;
          end
        end else if (sequence_step[sel] == STEP_1) begin
          if (cmd == UNLOCK_ADDR_2 && din == UNLOCK_DATA_2) begin
            seq_next  = STEP_2;
            mode_next = MODE_ERASE;
          end
        end else if (sequence_step[sel] == STEP_2) begin
          if (cmd == UNLOCK_ADDR_1 && din == CMD_CHIP_ERASE) begin
            act_next = ACT_CHIP_ERASE;
          end else if (din == CMD_SECTOR_ERASE) begin
            act_next    = ACT_SECTOR_ERASE;
            target_next = addr & SECTOR_MASK;
          end
        end
      end
      default: mode_next = MODE_READY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        chip_mode[i]        <= MODE_READY;
        sequence_step[i]    <= STEP_0;
        software_id_flag[i] <= 1'b0;
      end
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        chip_mode[sel]        <= mode_next;
        sequence_step[sel]    <= seq_next;
        software_id_flag[sel] <= id_next;
        m_tvalid              <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_action <= act_next;
      out_target <= target_next;
      out_data   <= data_next;
      out_id     <= id_next;
    end
  end

  always_comb begin
    m_tdata                        = '0;
    m_tdata[ADDRESS_BITS-1:0]      = out_target;
    m_tdata[ADDRESS_BITS +: 8]     = out_data;
    m_tdata[ADDRESS_BITS + 8]      = out_id;
    m_tuser                        = out_action;
  end

endmodule
